@@ rtl/rhe_pkg.sv @@
// ----------------------------------------------------------------------------
// rhe_pkg
// shared constants and types for the rgb histogram equalizer
// ----------------------------------------------------------------------------
package rhe_pkg;

  localparam int BIN_COUNT_DEFAULT   = 256;
  localparam int COUNT_WIDTH_DEFAULT = 22;
  localparam int PIX_W               = 23;
  localparam int LEVEL_W             = 8;
  localparam logic [PIX_W-1:0] PIXEL_COUNT_RESET = 23'd3000000;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_COUNT = 2'd1;
  localparam logic [1:0] OP_BUILD = 2'd2;
  localparam logic [1:0] OP_MAP   = 2'd3;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_BUILT = 1'b1;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [LEVEL_W-1:0] red_in;
    logic [LEVEL_W-1:0] green_in;
    logic [LEVEL_W-1:0] blue_in;
  } in_item_t;

  typedef struct packed {
    logic               kind;
    logic [LEVEL_W-1:0] red_out;
    logic [LEVEL_W-1:0] green_out;
    logic [LEVEL_W-1:0] blue_out;
  } out_item_t;

endpackage

@@ rtl/rhe_stream_if.sv @@
// ----------------------------------------------------------------------------
// rhe_stream_if
// valid/ready channel carrying one payload
// ----------------------------------------------------------------------------
interface rhe_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/rhe_divider.sv @@
// ----------------------------------------------------------------------------
// rhe_divider
// restoring divider, one quotient bit per cycle, result clamped to 255
// ----------------------------------------------------------------------------
module rhe_divider
  import rhe_pkg::*;
#(
  parameter int NUM_W = 40,
  parameter int DEN_W = 23
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [NUM_W-1:0]   num,
  input  logic [DEN_W-1:0]   den,
  output logic               done,
  output logic [LEVEL_W-1:0] quo
);
  localparam int CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] q;
  logic [DEN_W:0]   rem;
  logic [DEN_W-1:0] d;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic [DEN_W:0]   trial;

  assign trial = {rem[DEN_W-1:0], q[NUM_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NUM_W);
        q    <= num;
        d    <= den;
        rem  <= '0;
      end else if (busy) begin
        if (trial >= {1'b0, d}) begin
          rem <= trial - {1'b0, d};
          q   <= {q[NUM_W-2:0], 1'b1};
        end else begin
          rem <= trial;
          q   <= {q[NUM_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = (q > NUM_W'(255)) ? 8'hFF : q[LEVEL_W-1:0];
endmodule

@@ rtl/rgb_histogram_equalizer_unit.sv @@
// ----------------------------------------------------------------------------
// rgb_histogram_equalizer_unit
// per-channel histogram equalization of rgb pixels
// ----------------------------------------------------------------------------
// Count requests add each channel to a saturating histogram kept in block
// memory; count requests stream back to back while no result is held up at
// the output (a count to the same bin as the one before is forwarded). A map
// request holds off the input while the table read completes. A clear request
// sweeps every bin of the histogram memory, and the same clear pass runs after
// reset. A build request walks the bins one at a time, running three
// bit-serial dividers per bin (divider width NUM_W, 39 bits at the defaults),
// before its acknowledgement.
module rgb_histogram_equalizer_unit
  import rhe_pkg::*;
#(
  parameter int BIN_COUNT   = BIN_COUNT_DEFAULT,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [PIX_W-1:0] cfg_wdata,
  rhe_stream_if.sink       in_ch,
  rhe_stream_if.source     out_ch
);
  localparam int BW    = $clog2(BIN_COUNT);
  localparam int CUM_W = PIX_W > COUNT_WIDTH + BW ? PIX_W + 1 : COUNT_WIDTH + BW + 1;
  localparam int NUM_W = CUM_W + 8;
  localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

  localparam logic [2:0] ST_RUN   = 3'd0;
  localparam logic [2:0] ST_CLEAR = 3'd1;
  localparam logic [2:0] ST_FIRST = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_WAIT  = 3'd5;
  localparam logic [2:0] ST_ACK   = 3'd6;

  logic [PIX_W-1:0] pixel_count;
  logic [2:0]       state;
  logic [BW:0]      idx;

  logic [BW-1:0]            haddr, waddr_q;
  logic                     hwe, cnt_q;

  logic [CUM_W-1:0] cum [3];
  logic [CUM_W-1:0] first [3];
  logic [LEVEL_W-1:0] quo [3];
  logic [2:0]        ddone;
  logic              dstart;

  out_item_t obuf;
  logic      ovalid, map_q;

  function automatic logic [BW-1:0] bin_of(input logic [7:0] v);
    logic [BW-1:0] r;
    if (BW >= 8) r = BW'(v);
    else if (v >= 8'(BIN_COUNT - 1)) r = BW'(BIN_COUNT - 1);
    else r = v[BW-1:0];
    return r;
  endfunction

  assign in_ch.ready = (state == ST_RUN) && (!ovalid || out_ch.ready) && !map_q;
  wire acc = in_ch.valid && in_ch.ready;
  in_item_t req;
  assign req = in_ch.data;

  always_ff @(posedge clk) begin
    if (rst) pixel_count <= PIXEL_COUNT_RESET;
    else if (cfg_we) pixel_count <= cfg_wdata;
  end

  // histogram read address
  always_comb begin
    haddr = idx[BW-1:0];
    if (state == ST_RUN && acc && req.opcode == OP_COUNT) haddr = bin_of(req.red_in);
  end

  logic [BW-1:0] gaddr, baddr, gq, bq;
  logic [COUNT_WIDTH-1:0] hr, hg, hb, cr, cg, cb;

  // separate per-channel addressing via three memories
  logic [COUNT_WIDTH-1:0] hmr [BIN_COUNT];
  logic [COUNT_WIDTH-1:0] hmg [BIN_COUNT];
  logic [COUNT_WIDTH-1:0] hmb [BIN_COUNT];
  logic [BW-1:0] ra, qa;
  logic [COUNT_WIDTH-1:0] wr_r, wr_g, wr_b;
  logic [BW-1:0] qr;
  logic [BW-1:0] waddr_g, waddr_b;

  always_comb begin
    ra = haddr;
    gaddr = (state == ST_RUN) ? bin_of(req.green_in) : idx[BW-1:0];
    baddr = (state == ST_RUN) ? bin_of(req.blue_in) : idx[BW-1:0];
  end

  always_ff @(posedge clk) begin
    hr <= hmr[ra];
    hg <= hmg[gaddr];
    hb <= hmb[baddr];
    qr <= ra;
    gq <= gaddr;
    bq <= baddr;
  end

  // forward the value just written when the same bin comes right back
  always_comb begin
    cr = (hwe && waddr_q == qr) ? wr_r : hr;
    cg = (hwe && qa == gq) ? wr_g : hg;
    cb = (hwe && waddr_b == bq) ? wr_b : hb;
  end
  assign qa = waddr_g;

  logic [COUNT_WIDTH-1:0] nr, ng, nb;
  assign nr = (cr == CMAX) ? cr : cr + 1'b1;
  assign ng = (cg == CMAX) ? cg : cg + 1'b1;
  assign nb = (cb == CMAX) ? cb : cb + 1'b1;

  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) begin
      hmr[idx[BW-1:0]] <= '0;
      hmg[idx[BW-1:0]] <= '0;
      hmb[idx[BW-1:0]] <= '0;
    end else if (cnt_q) begin
      hmr[qr] <= nr;
      hmg[gq] <= ng;
      hmb[bq] <= nb;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) hwe <= 1'b0;
    else hwe <= cnt_q || state == ST_CLEAR;
    waddr_q <= (state == ST_CLEAR) ? idx[BW-1:0] : qr;
    waddr_g <= (state == ST_CLEAR) ? idx[BW-1:0] : gq;
    waddr_b <= (state == ST_CLEAR) ? idx[BW-1:0] : bq;
    wr_r <= (state == ST_CLEAR) ? '0 : nr;
    wr_g <= (state == ST_CLEAR) ? '0 : ng;
    wr_b <= (state == ST_CLEAR) ? '0 : nb;
  end

  // lookup table memories, one per channel
  logic lwe;
  logic [BW-1:0] lwa;
  logic [BW-1:0] lr_a, lg_a, lb_a;
  logic [LEVEL_W-1:0] lr_d, lg_d, lb_d;
  logic [LEVEL_W-1:0] lr_m [BIN_COUNT];
  logic [LEVEL_W-1:0] lg_m [BIN_COUNT];
  logic [LEVEL_W-1:0] lb_m [BIN_COUNT];
  assign lr_a = bin_of(req.red_in);
  assign lg_a = bin_of(req.green_in);
  assign lb_a = bin_of(req.blue_in);
  always_ff @(posedge clk) begin
    if (lwe) begin
      lr_m[lwa] <= quo[0];
      lg_m[lwa] <= quo[1];
      lb_m[lwa] <= quo[2];
    end
    lr_d <= lr_m[lr_a];
    lg_d <= lg_m[lg_a];
    lb_d <= lb_m[lb_a];
  end

  // tables read zero until the first build has written them
  logic built;

  // dividers
  genvar c;
  generate
    for (c = 0; c < 3; c++) begin : g_div
      logic             zero_div;
      logic [CUM_W-1:0] dn, span;
      logic [NUM_W-1:0] nm;
      assign zero_div = CUM_W'(pixel_count) <= first[c];
      assign dn       = CUM_W'(pixel_count) - first[c];
      assign span     = cum[c] - first[c];
      // times 255 as a shift and a subtract
      assign nm       = (NUM_W'(span) << 8) - NUM_W'(span);
      rhe_divider #(.NUM_W(NUM_W), .DEN_W(PIX_W)) u_div (
        .clk(clk), .rst(rst), .start(dstart),
        .num(zero_div ? '0 : nm),
        .den(zero_div ? PIX_W'(1) : dn[PIX_W-1:0]),
        .done(ddone[c]), .quo(quo[c])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_CLEAR;
      idx    <= '0;
      ovalid <= 1'b0;
      cnt_q  <= 1'b0;
      map_q  <= 1'b0;
      built  <= 1'b0;
      dstart <= 1'b0;
      lwe    <= 1'b0;
    end else begin
      cnt_q  <= 1'b0;
      dstart <= 1'b0;
      lwe    <= 1'b0;
      if (ovalid && out_ch.ready) ovalid <= 1'b0;
      if (map_q) begin
        map_q  <= 1'b0;
        ovalid <= 1'b1;
        obuf   <= '{KIND_PIXEL, built ? lr_d : '0, built ? lg_d : '0, built ? lb_d : '0};
      end
      case (state)
        ST_RUN: begin
          if (acc) begin
            case (req.opcode)
              OP_CLEAR: begin state <= ST_CLEAR; idx <= '0; end
              OP_COUNT: cnt_q <= 1'b1;
              OP_BUILD: begin state <= ST_FIRST; idx <= '0; end
              default:  map_q <= 1'b1;
            endcase
          end
        end
        ST_CLEAR: begin
          idx <= idx + 1'b1;
          if (idx == (BW+1)'(BIN_COUNT - 1)) state <= ST_RUN;
        end
        ST_FIRST: state <= ST_READ;  // bin read in flight, counts settled
        ST_READ: begin
          if (idx == '0) begin
            first[0] <= CUM_W'(cr); first[1] <= CUM_W'(cg); first[2] <= CUM_W'(cb);
            cum[0] <= CUM_W'(cr); cum[1] <= CUM_W'(cg); cum[2] <= CUM_W'(cb);
          end else begin
            cum[0] <= cum[0] + CUM_W'(cr);
            cum[1] <= cum[1] + CUM_W'(cg);
            cum[2] <= cum[2] + CUM_W'(cb);
          end
          state <= ST_DIV;
        end
        ST_DIV: begin dstart <= 1'b1; state <= ST_WAIT; end
        ST_WAIT: begin
          if (ddone[0]) begin
            lwe <= 1'b1;
            lwa <= idx[BW-1:0];
            idx <= idx + 1'b1;
            if (idx == (BW+1)'(BIN_COUNT - 1)) state <= ST_ACK;
            else state <= ST_FIRST;
          end
        end
        ST_ACK: begin
          if (!ovalid || out_ch.ready) begin
            built  <= 1'b1;
            ovalid <= 1'b1;
            obuf   <= '{KIND_BUILT, 8'd0, 8'd0, 8'd0};
            state  <= ST_RUN;
          end
        end
        default: state <= ST_RUN;
      endcase
    end
  end

  assign out_ch.valid = ovalid;
  assign out_ch.data  = obuf;
endmodule

@@ test/rhe_tb_pkg.sv @@
// ----------------------------------------------------------------------------
// rhe_tb_pkg
// shared test constants for the equalizer testbench
// ----------------------------------------------------------------------------
package rhe_tb_pkg;

  localparam int BUILD_CYCLES    = 256 * 48;
  localparam int WATCHDOG_LIMIT  = BUILD_CYCLES * 8 + 4000;

endpackage

@@ test/rgb_histogram_equalizer_unit_checker.sv @@
// ----------------------------------------------------------------------------
// rgb_histogram_equalizer_unit_checker
// tracks histograms and lookup tables from the accepted requests and checks
// every result against them, in order
// ----------------------------------------------------------------------------
module rgb_histogram_equalizer_unit_checker
  import rhe_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [PIX_W-1:0] cfg_wdata,
  rhe_stream_if            in_ch,
  rhe_stream_if            out_ch,
  output int               fail_count,
  output int               pending,
  output int               mapped_seen,
  output int               builds_seen
);

  localparam int COUNT_MAX = (1 << COUNT_WIDTH_DEFAULT) - 1;

  logic [PIX_W-1:0] frame_pixels;
  int               hist[3][256];
  logic [7:0]       lut[3][256];
  out_item_t        expected_q[$];

  initial fail_count = 0;
  assign pending = expected_q.size();

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic build_luts();
    longint first, cum, n, q;
    for (int c = 0; c < 3; c++) begin
      first = hist[c][0];
      n = frame_pixels;
      cum = 0;
      for (int v = 0; v < 256; v++) begin
        cum += hist[c][v];
        if (n <= first) begin
          q = 0;
        end else begin
          q = ((cum - first) * 255) / (n - first);
          if (q > 255) q = 255;
        end
        lut[c][v] = q[7:0];
      end
    end
  endtask

  task automatic predict(input in_item_t it);
    out_item_t r;
    logic [7:0] px[3];
    px[0] = it.red_in;
    px[1] = it.green_in;
    px[2] = it.blue_in;
    case (it.opcode)
      OP_CLEAR: begin
        foreach (hist[c, v]) hist[c][v] = 0;
      end
      OP_COUNT: begin
        for (int c = 0; c < 3; c++)
          if (hist[c][px[c]] < COUNT_MAX) hist[c][px[c]]++;
      end
      OP_BUILD: begin
        build_luts();
        r = '{kind: KIND_BUILT, red_out: 8'd0, green_out: 8'd0, blue_out: 8'd0};
        expected_q.push_back(r);
      end
      default: begin
        r = '{kind: KIND_PIXEL, red_out: lut[0][px[0]], green_out: lut[1][px[1]],
              blue_out: lut[2][px[2]]};
        expected_q.push_back(r);
      end
    endcase
  endtask

  task automatic compare(input out_item_t got);
    out_item_t want;
    if (expected_q.size() == 0) begin
      report($sformatf("unexpected result %h", got));
      return;
    end
    want = expected_q.pop_front();
    if (got.kind !== want.kind)
      report($sformatf("kind got %0d want %0d", got.kind, want.kind));
    if (got.red_out !== want.red_out)
      report($sformatf("red got %0d want %0d", got.red_out, want.red_out));
    if (got.green_out !== want.green_out)
      report($sformatf("green got %0d want %0d", got.green_out, want.green_out));
    if (got.blue_out !== want.blue_out)
      report($sformatf("blue got %0d want %0d", got.blue_out, want.blue_out));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      frame_pixels = PIXEL_COUNT_RESET;
      foreach (hist[c, v]) hist[c][v] = 0;
      foreach (lut[c, v]) lut[c][v] = 8'd0;
      expected_q.delete();
      mapped_seen = 0;
      builds_seen = 0;
    end else begin
      if (cfg_we) frame_pixels = cfg_wdata;
      if (out_ch.valid && out_ch.ready) begin
        if (out_ch.data.kind == KIND_BUILT) builds_seen++;
        else mapped_seen++;
        compare(out_ch.data);
      end
      if (in_ch.valid && in_ch.ready) predict(in_ch.data);
    end
  end

endmodule

@@ test/rgb_histogram_equalizer_unit_tb.sv @@
// ----------------------------------------------------------------------------
// rgb_histogram_equalizer_unit_tb
// drives clear, count, build and map requests over several pixel counts with bursty
// input and a stalling output; a side checker predicts and compares results
// ----------------------------------------------------------------------------
module rgb_histogram_equalizer_unit_tb;
  import rhe_pkg::*;
  import rhe_tb_pkg::*;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic [PIX_W-1:0] cfg_wdata = '0;
  int               fail_count, pending, mapped_seen, builds_seen;
  int               idle_cycles = 0;
  int               burst_left = 0;
  int               sent = 0;
  bit               stall_mode = 1'b0;
  logic [7:0]       stall_pat = 8'hff;

  rhe_stream_if #(in_item_t)  in_ch();
  rhe_stream_if #(out_item_t) out_ch();

  rgb_histogram_equalizer_unit dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  rgb_histogram_equalizer_unit_checker checker_i (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch), .out_ch(out_ch), .fail_count(fail_count),
    .pending(pending), .mapped_seen(mapped_seen), .builds_seen(builds_seen)
  );

  always #10 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  function automatic logic [7:0] rnd8();
    return 8'($urandom);
  endfunction

  // receiver: rotating stall pattern, reshuffled now and then
  always @(negedge clk) begin
    if (!rst) begin
      if ($urandom_range(0, 63) == 0) begin
        stall_mode <= 1'($urandom_range(0, 1));
        stall_pat <= 8'($urandom);
      end else begin
        stall_pat <= {stall_pat[6:0], stall_pat[7]};
      end
      out_ch.ready <= stall_mode ? stall_pat[0] : 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("watchdog expired, %0d results pending", pending);
      $display("rgb_histogram_equalizer_unit verification failed");
      $finish;
    end
  end

  task automatic send(input logic [1:0] op, input logic [7:0] r, g, b);
    in_item_t it;
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    it.opcode = op;
    it.red_in = r;
    it.green_in = g;
    it.blue_in = b;
    in_ch.data <= it;
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    burst_left--;
    sent++;
  endtask

  task automatic go_idle();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic set_frame(input logic [PIX_W-1:0] n);
    go_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= n;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // one frame: clear, count, build, then map
  task automatic frame(input int counts, input int maps, input bit narrow);
    logic [7:0] base;
    base = rnd8();
    send(OP_CLEAR, rnd8(), rnd8(), rnd8());
    repeat (counts) begin
      if (narrow)
        send(OP_COUNT, base + 8'($urandom_range(0, 7)), base ^ 8'($urandom_range(0, 3)),
             8'($urandom_range(0, 15)));
      else
        send(OP_COUNT, rnd8(), rnd8(), rnd8());
    end
    send(OP_BUILD, rnd8(), rnd8(), rnd8());
    repeat (maps) send(OP_MAP, rnd8(), rnd8(), rnd8());
  endtask

  initial begin
    int n;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // map before any build gives zeros
    send(OP_MAP, 8'h00, 8'hff, 8'h5a);
    send(OP_MAP, 8'hff, 8'h00, 8'ha5);
    send(OP_BUILD, 8'hff, 8'hff, 8'hff);
    send(OP_MAP, 8'h80, 8'h01, 8'hfe);
    set_frame(23'd8);
    send(OP_COUNT, 8'h00, 8'hff, 8'h55);
    send(OP_COUNT, 8'hff, 8'h00, 8'haa);
    send(OP_COUNT, 8'hff, 8'h00, 8'haa);
    send(OP_COUNT, 8'h7f, 8'h80, 8'h01);
    send(OP_BUILD, 8'h00, 8'h00, 8'h00);
    send(OP_MAP, 8'h00, 8'h00, 8'h00);
    send(OP_MAP, 8'hff, 8'hff, 8'hff);
    send(OP_MAP, 8'h7f, 8'h80, 8'haa);
    // counts beyond the pixel count saturate at 255
    set_frame(23'd2);
    send(OP_BUILD, 8'h00, 8'h00, 8'h00);
    send(OP_MAP, 8'hff, 8'h80, 8'haa);
    // divisor not positive: frame of one, with a pixel at bin 0 in every channel
    set_frame(23'd1);
    send(OP_CLEAR, 8'h00, 8'h00, 8'h00);
    send(OP_COUNT, 8'h00, 8'h00, 8'h00);
    send(OP_COUNT, 8'h00, 8'h01, 8'hff);
    send(OP_BUILD, 8'h00, 8'h00, 8'h00);
    send(OP_MAP, 8'h00, 8'h01, 8'hff);
    send(OP_MAP, 8'hff, 8'hff, 8'h01);

    for (int ph = 0; ph < 14; ph++) begin
      case (ph % 4)
        0: n = 1 << 22;
        1: n = $urandom_range(1, 64);
        2: n = $urandom_range(100, 300);
        default: n = (ph == 11) ? 23'h7fffff : $urandom_range(1, 4000);
      endcase
      set_frame(n[PIX_W-1:0]);
      frame($urandom_range(20, 110), $urandom_range(20, 70), ph[0]);
      // random mix within the frame, builds kept rare
      repeat ($urandom_range(5, 20)) begin
        n = $urandom_range(0, 31);
        send(n == 0 ? OP_BUILD : (n < 14 ? OP_COUNT : OP_MAP),
             rnd8(), rnd8(), rnd8());
      end
    end
    // restore the reset frame size with a last frame
    set_frame(PIXEL_COUNT_RESET);
    frame(60, 40, 1'b0);

    go_idle();
    $display("sent %0d requests: %0d mapped pixels and %0d builds checked",
             sent, mapped_seen, builds_seen);
    $display("pixel counts 1 to 2^23-1 including the reset value");
    if (fail_count == 0)
      $display("rgb_histogram_equalizer_unit verification clean");
    else
      $display("rgb_histogram_equalizer_unit verification failed");
    $finish;
  end

endmodule

@@ rgb_histogram_equalizer_unit.f @@
rtl/rhe_pkg.sv
rtl/rhe_stream_if.sv
rtl/rhe_divider.sv
rtl/rgb_histogram_equalizer_unit.sv
test/rhe_tb_pkg.sv
test/rgb_histogram_equalizer_unit_checker.sv
test/rgb_histogram_equalizer_unit_tb.sv
